[rtl/ncm_pkg.sv]
// Shared types, widths and codes of the nearest corner matcher.
`default_nettype none

package ncm_pkg;

    // Table size and index widths
    localparam int MAX_CORNERS = 256;
    localparam int IDX_W       = $clog2(MAX_CORNERS);
    localparam int CNT_W       = IDX_W + 1;

    // Field widths
    localparam int COORD_W = 16;
    localparam int GRID_W  = 8;
    localparam int VOTE_W  = 8;
    localparam int INDEX_W = 8;
    localparam int REG_W   = 16;
    localparam int FRAME_W = 16;

    // Distance and square-root widths
    localparam int SQ_W       = 2 * COORD_W + 1;
    localparam int ROOT_W     = COORD_W + 1;
    localparam int OP_W       = 2 * ROOT_W;
    localparam int REM_W      = ROOT_W + 1;
    localparam int SQRT_CNT_W = $clog2(ROOT_W);
    localparam logic [SQRT_CNT_W-1:0] SQRT_LAST = SQRT_CNT_W'(ROOT_W - 1);

    typedef enum logic [1:0] {
        MODE_START = 2'd0,
        MODE_LOAD  = 2'd1,
        MODE_QUERY = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        STAT_ACCEPTED   = 3'd0,
        STAT_FAR        = 3'd1,
        STAT_AMBIGUOUS  = 3'd2,
        STAT_CLAIMED    = 3'd3,
        STAT_TOO_OLD    = 3'd4,
        STAT_NO_CORNERS = 3'd5,
        STAT_DONE       = 3'd6,
        STAT_FULL       = 3'd7
    } t_status;

    typedef enum logic [1:0] {
        CFG_MATCH_RADIUS   = 2'd0,
        CFG_MIN_MARGIN     = 2'd1,
        CFG_MAX_AGE        = 2'd2,
        CFG_IDENTITY_FRAME = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_CHECK,
        S_SQRT_SEC,
        S_SQRT_BEST,
        S_MARGIN,
        S_CLAIM,
        S_FETCH,
        S_RESULT
    } t_state;

    typedef struct packed {
        t_mode              mode;
        logic [COORD_W-1:0] point_u;
        logic [COORD_W-1:0] point_v;
        logic [GRID_W-1:0]  grid_row;
        logic [GRID_W-1:0]  grid_col;
        logic [VOTE_W-1:0]  vote_count;
        logic [FRAME_W-1:0] frame_number;
    } t_in;

    typedef struct packed {
        t_status            status;
        logic [INDEX_W-1:0] match_index;
        logic [COORD_W-1:0] match_u;
        logic [COORD_W-1:0] match_v;
        logic [GRID_W-1:0]  match_row;
        logic [GRID_W-1:0]  match_col;
        logic [VOTE_W-1:0]  votes_out;
    } t_out;

    typedef struct packed {
        logic [COORD_W-1:0] u;
        logic [COORD_W-1:0] v;
        logic [GRID_W-1:0]  row;
        logic [GRID_W-1:0]  col;
    } t_entry;

endpackage

`default_nettype wire

[rtl/nearest_corner_matcher_with_margin_top.sv]
// Nearest corner matcher: corner table, scan pipeline, shared square-root unit.
// Start-frame and load requests go straight to the result register on accept.
// A query reads one table entry per cycle into the distance pipeline; given a margin
// and a runner-up, two 17-step square roots run on one shared bit-serial root unit.
// One request is worked at a time; a finished result waits in the output register.
// Reset empties the table count and clears all claim marks at once; no clearing pass.
`default_nettype none

module nearest_corner_matcher_with_margin_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire ncm_pkg::t_in                  i_in_data,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output ncm_pkg::t_out                      o_out_data,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire ncm_pkg::t_cfg_idx             i_cfg_index,
    input  wire logic [ncm_pkg::REG_W-1:0]     i_cfg_data
);

    // Configuration registers
    logic [ncm_pkg::REG_W-1:0] r_radius;
    logic [ncm_pkg::REG_W-1:0] r_margin;
    logic [ncm_pkg::REG_W-1:0] r_max_age;
    logic [ncm_pkg::REG_W-1:0] r_id_frame;

    // Control state
    ncm_pkg::t_state                r_state, n_state;
    logic [ncm_pkg::CNT_W-1:0]      r_count, n_count;
    logic [ncm_pkg::MAX_CORNERS-1:0] r_claim, n_claim;
    logic [ncm_pkg::CNT_W-1:0]      r_scan_idx, n_scan_idx;
    logic                           r_p0, r_p1, r_p2, n_p0;
    logic                           r_have_best, n_have_best;
    logic                           r_have_second, n_have_second;
    logic                           r_out_valid, n_out_valid;
    logic [ncm_pkg::SQRT_CNT_W-1:0] r_sq_cnt, n_sq_cnt;

    // Request operands
    logic [ncm_pkg::COORD_W-1:0] r_pu, n_pu;
    logic [ncm_pkg::COORD_W-1:0] r_pv, n_pv;
    logic [ncm_pkg::VOTE_W-1:0]  r_votes, n_votes;
    logic [ncm_pkg::FRAME_W-1:0] r_age, n_age;
    logic [2*ncm_pkg::REG_W-1:0] r_r2, n_r2;

    // Corner table and distance pipeline
    ncm_pkg::t_entry             r_mem [ncm_pkg::MAX_CORNERS];
    ncm_pkg::t_entry             r_mem_q;
    logic [ncm_pkg::IDX_W-1:0]   w_rd_addr;
    logic                        w_wr_en;
    logic [ncm_pkg::IDX_W-1:0]   r_idx0, r_idx1, r_idx2;
    logic [ncm_pkg::COORD_W-1:0] w_du, w_dv;
    logic [2*ncm_pkg::COORD_W-1:0] r_sq_u, r_sq_v;
    logic [ncm_pkg::SQ_W-1:0]    r_dist;

    // Best and second best
    logic [ncm_pkg::SQ_W-1:0]  r_best_sq, n_best_sq;
    logic [ncm_pkg::SQ_W-1:0]  r_second_sq, n_second_sq;
    logic [ncm_pkg::IDX_W-1:0] r_best_idx, n_best_idx;

    // Square-root unit
    logic [ncm_pkg::OP_W-1:0]    r_sq_op, n_sq_op;
    logic [ncm_pkg::REM_W-1:0]   r_sq_rem, n_sq_rem;
    logic [ncm_pkg::ROOT_W-1:0]  r_sq_root, n_sq_root;
    logic [ncm_pkg::ROOT_W-1:0]  r_root_sec, n_root_sec;
    logic [ncm_pkg::REM_W+1:0]   w_rem_sh, w_trial, w_rem_sub;
    logic                        w_fits;
    logic [ncm_pkg::REM_W-1:0]   w_rem_nx;
    logic [ncm_pkg::ROOT_W-1:0]  w_root_nx;

    // Results
    ncm_pkg::t_out r_res, n_res;
    ncm_pkg::t_out r_out, n_out;

    // Request decode
    logic                        w_in_acc;
    logic [ncm_pkg::FRAME_W:0]   w_age_full;
    logic                        w_too_old;
    logic [ncm_pkg::ROOT_W-1:0]  w_root_gap;

    assign o_in_stall  = (r_state != ncm_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_age_full = {1'b0, i_in_data.frame_number} - {1'b0, r_id_frame};
    assign w_too_old  = w_age_full[ncm_pkg::FRAME_W]
                        || (w_age_full[ncm_pkg::FRAME_W-1:0] > r_max_age);

    // Table write on a load that fits; read by scan or by the claimed index
    assign w_wr_en   = w_in_acc && (i_in_data.mode == ncm_pkg::MODE_LOAD)
                       && (r_count < ncm_pkg::CNT_W'(ncm_pkg::MAX_CORNERS));
    assign w_rd_addr = (r_state == ncm_pkg::S_CLAIM) ? r_best_idx
                                                     : r_scan_idx[ncm_pkg::IDX_W-1:0];

    // Absolute coordinate differences of the entry just read
    assign w_du = (r_mem_q.u >= r_pu) ? (r_mem_q.u - r_pu) : (r_pu - r_mem_q.u);
    assign w_dv = (r_mem_q.v >= r_pv) ? (r_mem_q.v - r_pv) : (r_pv - r_mem_q.v);

    // One restoring square-root step: two operand bits in, one root bit out
    assign w_rem_sh  = {r_sq_rem, r_sq_op[ncm_pkg::OP_W-1 -: 2]};
    assign w_trial   = (ncm_pkg::REM_W+2)'({r_sq_root, 2'b01});
    assign w_fits    = (w_rem_sh >= w_trial);
    assign w_rem_sub = w_rem_sh - w_trial;
    assign w_rem_nx  = w_fits ? w_rem_sub[ncm_pkg::REM_W-1:0] : w_rem_sh[ncm_pkg::REM_W-1:0];
    assign w_root_nx = {r_sq_root[ncm_pkg::ROOT_W-2:0], w_fits};

    assign w_root_gap = r_root_sec - r_sq_root;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius   <= ncm_pkg::REG_W'(128);
            r_margin   <= '0;
            r_max_age  <= ncm_pkg::REG_W'(10);
            r_id_frame <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                ncm_pkg::CFG_MATCH_RADIUS:   r_radius   <= i_cfg_data;
                ncm_pkg::CFG_MIN_MARGIN:     r_margin   <= i_cfg_data;
                ncm_pkg::CFG_MAX_AGE:        r_max_age  <= i_cfg_data;
                ncm_pkg::CFG_IDENTITY_FRAME: r_id_frame <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Corner table memory
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_count[ncm_pkg::IDX_W-1:0]] <= '{u:   i_in_data.point_u,
                                                   v:   i_in_data.point_v,
                                                   row: i_in_data.grid_row,
                                                   col: i_in_data.grid_col};
        end
        r_mem_q <= r_mem[w_rd_addr];
    end

    // Distance pipeline: read, square, sum
    always_ff @(posedge i_clk) begin
        r_idx0 <= w_rd_addr;
        r_idx1 <= r_idx0;
        r_idx2 <= r_idx1;
        r_sq_u <= w_du * w_du;
        r_sq_v <= w_dv * w_dv;
        r_dist <= ncm_pkg::SQ_W'(r_sq_u) + ncm_pkg::SQ_W'(r_sq_v);
    end

    // Sequencer, compare stage, root unit and result build
    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_claim       = r_claim;
        n_scan_idx    = r_scan_idx;
        n_p0          = 1'b0;
        n_have_best   = r_have_best;
        n_have_second = r_have_second;
        n_out_valid   = r_out_valid;
        n_sq_cnt      = r_sq_cnt;
        n_pu          = r_pu;
        n_pv          = r_pv;
        n_votes       = r_votes;
        n_age         = r_age;
        n_r2          = r_r2;
        n_best_sq     = r_best_sq;
        n_second_sq   = r_second_sq;
        n_best_idx    = r_best_idx;
        n_sq_op       = r_sq_op;
        n_sq_rem      = r_sq_rem;
        n_sq_root     = r_sq_root;
        n_root_sec    = r_root_sec;
        n_res         = r_res;
        n_out         = r_out;

        // Drop the output once taken
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        // Keep the nearest and second nearest; ties go to the earlier index
        if (r_p2) begin
            if (!r_have_best) begin
                n_have_best = 1'b1;
                n_best_sq   = r_dist;
                n_best_idx  = r_idx2;
            end else if (r_dist < r_best_sq) begin
                n_second_sq   = r_best_sq;
                n_have_second = 1'b1;
                n_best_sq     = r_dist;
                n_best_idx    = r_idx2;
            end else if (!r_have_second || (r_dist < r_second_sq)) begin
                n_second_sq   = r_dist;
                n_have_second = 1'b1;
            end
        end

        case (r_state)
            ncm_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    n_res        = '0;
                    n_res.status = ncm_pkg::STAT_DONE;
                    n_state      = ncm_pkg::S_RESULT;
                    case (i_in_data.mode)
                        ncm_pkg::MODE_START: begin
                            n_count = '0;
                            n_claim = '0;
                        end
                        ncm_pkg::MODE_LOAD: begin
                            if (w_wr_en) begin
                                n_count = r_count + 1'b1;
                            end else begin
                                n_res.status = ncm_pkg::STAT_FULL;
                            end
                        end
                        ncm_pkg::MODE_QUERY: begin
                            if (w_too_old) begin
                                n_res.status = ncm_pkg::STAT_TOO_OLD;
                            end else if (r_count == '0) begin
                                n_res.status = ncm_pkg::STAT_NO_CORNERS;
                            end else begin
                                n_pu          = i_in_data.point_u;
                                n_pv          = i_in_data.point_v;
                                n_votes       = i_in_data.vote_count;
                                n_age         = w_age_full[ncm_pkg::FRAME_W-1:0];
                                n_r2          = r_radius * r_radius;
                                n_scan_idx    = '0;
                                n_have_best   = 1'b0;
                                n_have_second = 1'b0;
                                n_state       = ncm_pkg::S_SCAN;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            // Issue one table read per cycle, then let the pipeline drain
            ncm_pkg::S_SCAN: begin
                if (r_scan_idx < r_count) begin
                    n_p0       = 1'b1;
                    n_scan_idx = r_scan_idx + 1'b1;
                end else if (!r_p0 && !r_p1 && !r_p2) begin
                    n_state = ncm_pkg::S_CHECK;
                end
            end

            ncm_pkg::S_CHECK: begin
                if (r_best_sq > ncm_pkg::SQ_W'(r_r2)) begin
                    n_res        = '0;
                    n_res.status = ncm_pkg::STAT_FAR;
                    n_state      = ncm_pkg::S_RESULT;
                end else if ((r_margin != '0) && r_have_second) begin
                    n_sq_op   = ncm_pkg::OP_W'(r_second_sq);
                    n_sq_rem  = '0;
                    n_sq_root = '0;
                    n_sq_cnt  = '0;
                    n_state   = ncm_pkg::S_SQRT_SEC;
                end else begin
                    n_state = ncm_pkg::S_CLAIM;
                end
            end

            // Root of the second best, then reload the unit with the best
            ncm_pkg::S_SQRT_SEC: begin
                n_sq_op   = r_sq_op << 2;
                n_sq_rem  = w_rem_nx;
                n_sq_root = w_root_nx;
                n_sq_cnt  = r_sq_cnt + 1'b1;
                if (r_sq_cnt == ncm_pkg::SQRT_LAST) begin
                    n_root_sec = w_root_nx;
                    n_sq_op    = ncm_pkg::OP_W'(r_best_sq);
                    n_sq_rem   = '0;
                    n_sq_root  = '0;
                    n_sq_cnt   = '0;
                    n_state    = ncm_pkg::S_SQRT_BEST;
                end
            end

            ncm_pkg::S_SQRT_BEST: begin
                n_sq_op   = r_sq_op << 2;
                n_sq_rem  = w_rem_nx;
                n_sq_root = w_root_nx;
                n_sq_cnt  = r_sq_cnt + 1'b1;
                if (r_sq_cnt == ncm_pkg::SQRT_LAST) begin
                    n_sq_cnt = '0;
                    n_state  = ncm_pkg::S_MARGIN;
                end
            end

            ncm_pkg::S_MARGIN: begin
                if (w_root_gap < ncm_pkg::ROOT_W'(r_margin)) begin
                    n_res        = '0;
                    n_res.status = ncm_pkg::STAT_AMBIGUOUS;
                    n_state      = ncm_pkg::S_RESULT;
                end else begin
                    n_state = ncm_pkg::S_CLAIM;
                end
            end

            // Claim the best corner; its entry is read in this cycle
            ncm_pkg::S_CLAIM: begin
                if (r_claim[r_best_idx]) begin
                    n_res        = '0;
                    n_res.status = ncm_pkg::STAT_CLAIMED;
                    n_state      = ncm_pkg::S_RESULT;
                end else begin
                    n_claim[r_best_idx] = 1'b1;
                    n_state             = ncm_pkg::S_FETCH;
                end
            end

            ncm_pkg::S_FETCH: begin
                n_res.status      = ncm_pkg::STAT_ACCEPTED;
                n_res.match_index = ncm_pkg::INDEX_W'(r_best_idx);
                n_res.match_u     = r_mem_q.u;
                n_res.match_v     = r_mem_q.v;
                n_res.match_row   = r_mem_q.row;
                n_res.match_col   = r_mem_q.col;
                if (r_age > ncm_pkg::FRAME_W'(r_votes)) begin
                    n_res.votes_out = '0;
                end else begin
                    n_res.votes_out = r_votes - r_age[ncm_pkg::VOTE_W-1:0];
                end
                n_state = ncm_pkg::S_RESULT;
            end

            // Hand the result to the output register once it is free
            ncm_pkg::S_RESULT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = ncm_pkg::S_IDLE;
                end
            end

            default: n_state = ncm_pkg::S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ncm_pkg::S_IDLE;
            r_count       <= '0;
            r_claim       <= '0;
            r_scan_idx    <= '0;
            r_p0          <= 1'b0;
            r_p1          <= 1'b0;
            r_p2          <= 1'b0;
            r_have_best   <= 1'b0;
            r_have_second <= 1'b0;
            r_out_valid   <= 1'b0;
            r_sq_cnt      <= '0;
        end else begin
            r_state       <= n_state;
            r_count       <= n_count;
            r_claim       <= n_claim;
            r_scan_idx    <= n_scan_idx;
            r_p0          <= n_p0;
            r_p1          <= r_p0;
            r_p2          <= r_p1;
            r_have_best   <= n_have_best;
            r_have_second <= n_have_second;
            r_out_valid   <= n_out_valid;
            r_sq_cnt      <= n_sq_cnt;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_pu        <= n_pu;
        r_pv        <= n_pv;
        r_votes     <= n_votes;
        r_age       <= n_age;
        r_r2        <= n_r2;
        r_best_sq   <= n_best_sq;
        r_second_sq <= n_second_sq;
        r_best_idx  <= n_best_idx;
        r_sq_op     <= n_sq_op;
        r_sq_rem    <= n_sq_rem;
        r_sq_root   <= n_sq_root;
        r_root_sec  <= n_root_sec;
        r_res       <= n_res;
        r_out       <= n_out;
    end

    // The table count never passes its depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= ncm_pkg::CNT_W'(ncm_pkg::MAX_CORNERS))
        else $error("corner count beyond table depth");

    // Second best is never nearer than best
    a_best_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_have_second && r_have_best) |-> (r_best_sq <= r_second_sq))
        else $error("second best nearer than best");

    // Distance pipeline only carries entries while scanning
    a_pipe_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_p0 || r_p1 || r_p2) |-> (r_state == ncm_pkg::S_SCAN))
        else $error("scan pipeline busy outside scan");

    // Leaving the scan requires a drained pipeline
    a_scan_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ncm_pkg::S_SCAN) && (n_state == ncm_pkg::S_CHECK)
        |-> (!r_p0 && !r_p1 && !r_p2 && r_have_best))
        else $error("scan left before last distance compared");

endmodule

`default_nettype wire

[bench/ncm_checker.sv]
// Scoreboard for the nearest corner matcher: watches all channels, predicts and compares.
`default_nettype none

module ncm_checker
    import ncm_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic             i_in_stall,
    input  wire t_in              i_in_data,
    input  wire logic             i_out_valid,
    input  wire logic             i_out_stall,
    input  wire t_out             i_out_data,
    input  wire logic             i_cfg_valid,
    input  wire logic             i_cfg_ready,
    input  wire t_cfg_idx         i_cfg_index,
    input  wire logic [REG_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam int PRINT_CAP = 40;

    // Shadow of the corner table, claim marks and registers
    t_entry           corners [MAX_CORNERS];
    bit               claimed [MAX_CORNERS];
    int               n_corners;
    logic [REG_W-1:0] radius_r;
    logic [REG_W-1:0] margin_r;
    logic [REG_W-1:0] max_age_r;
    logic [REG_W-1:0] id_frame_r;

    // Results still owed by the block, oldest first
    t_out match_results_q [$];

    function automatic longint unsigned dist_sq(t_entry e, logic [COORD_W-1:0] u,
                                                logic [COORD_W-1:0] v);
        longint unsigned du;
        longint unsigned dv;
        du = (e.u >= u) ? e.u - u : u - e.u;
        dv = (e.v >= v) ? e.v - v : v - e.v;
        return du * du + dv * dv;
    endfunction

    // Floor square root, one result bit per step from the top
    function automatic longint unsigned isqrt(longint unsigned n);
        longint unsigned root;
        longint unsigned cand;
        int              b;
        root = 0;
        for (b = ROOT_W; b >= 0; b--) begin
            cand = root | (64'd1 << b);
            if (cand * cand <= n) root = cand;
        end
        return root;
    endfunction

    // Work out the answer to one request and advance the shadow state
    function automatic t_out predict_match(t_in req);
        t_out            res;
        int              age;
        int              idx;
        int              best_i;
        int              left;
        longint unsigned best_d;
        longint unsigned second_d;
        longint unsigned d;
        longint unsigned r2;
        bit              have_second;
        res        = '0;
        res.status = STAT_DONE;
        case (req.mode)
            MODE_START: begin
                n_corners = 0;
                foreach (claimed[k]) claimed[k] = 1'b0;
            end
            MODE_LOAD: begin
                if (n_corners >= MAX_CORNERS) begin
                    res.status = STAT_FULL;
                end else begin
                    corners[n_corners] = '{req.point_u, req.point_v, req.grid_row,
                                           req.grid_col};
                    n_corners++;
                end
            end
            MODE_QUERY: begin
                age = int'(req.frame_number) - int'(id_frame_r);
                if (age < 0 || age > int'(max_age_r)) begin
                    res.status = STAT_TOO_OLD;
                end else if (n_corners == 0) begin
                    res.status = STAT_NO_CORNERS;
                end else begin
                    // Scan for nearest and runner-up; ties keep the earlier index as best
                    best_i      = 0;
                    best_d      = dist_sq(corners[0], req.point_u, req.point_v);
                    second_d    = 0;
                    have_second = 1'b0;
                    for (idx = 1; idx < n_corners; idx++) begin
                        d = dist_sq(corners[idx], req.point_u, req.point_v);
                        if (d < best_d) begin
                            second_d    = best_d;
                            have_second = 1'b1;
                            best_d      = d;
                            best_i      = idx;
                        end else if (!have_second || d < second_d) begin
                            second_d    = d;
                            have_second = 1'b1;
                        end
                    end
                    r2 = radius_r;
                    r2 = r2 * r2;
                    if (best_d > r2) begin
                        res.status = STAT_FAR;
                    end else if (margin_r != 0 && have_second &&
                                 isqrt(second_d) - isqrt(best_d) <
                                 longint'(margin_r)) begin
                        res.status = STAT_AMBIGUOUS;
                    end else if (claimed[best_i]) begin
                        res.status = STAT_CLAIMED;
                    end else begin
                        claimed[best_i] = 1'b1;
                        left            = int'(req.vote_count) - age;
                        res.status      = STAT_ACCEPTED;
                        res.match_index = best_i[INDEX_W-1:0];
                        res.match_u     = corners[best_i].u;
                        res.match_v     = corners[best_i].v;
                        res.match_row   = corners[best_i].row;
                        res.match_col   = corners[best_i].col;
                        res.votes_out   = (left > 0) ? left[VOTE_W-1:0] : '0;
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // Print one line per mismatch (up to a cap) and count it
    task automatic report_mismatch(string what, longint unsigned got,
                                   longint unsigned want);
        o_fail_count++;
        if (o_fail_count <= PRINT_CAP)
            $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    task automatic compare_result(t_out got, t_out want);
        if (got.status != want.status)
            report_mismatch("status", got.status, want.status);
        if (got.match_index != want.match_index)
            report_mismatch("match_index", got.match_index, want.match_index);
        if (got.match_u != want.match_u)
            report_mismatch("match_u", got.match_u, want.match_u);
        if (got.match_v != want.match_v)
            report_mismatch("match_v", got.match_v, want.match_v);
        if (got.match_row != want.match_row)
            report_mismatch("match_row", got.match_row, want.match_row);
        if (got.match_col != want.match_col)
            report_mismatch("match_col", got.match_col, want.match_col);
        if (got.votes_out != want.votes_out)
            report_mismatch("votes_out", got.votes_out, want.votes_out);
    endtask

    // Track register writes, requests and results at each edge
    always @(posedge i_clk) begin : watch
        t_out want;
        if (!i_rst_n) begin
            n_corners  = 0;
            foreach (claimed[k]) claimed[k] = 1'b0;
            radius_r   = 16'd128;
            margin_r   = '0;
            max_age_r  = 16'd10;
            id_frame_r = '0;
            match_results_q.delete();
            o_fail_count = 0;
            o_pending    <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_MATCH_RADIUS:   radius_r   = i_cfg_data;
                    CFG_MIN_MARGIN:     margin_r   = i_cfg_data;
                    CFG_MAX_AGE:        max_age_r  = i_cfg_data;
                    CFG_IDENTITY_FRAME: id_frame_r = i_cfg_data;
                    default: ;
                endcase
            end
            // Retire the result before queueing a request taken on the same edge
            if (i_out_valid && !i_out_stall) begin
                if (match_results_q.size() == 0) begin
                    report_mismatch("unexpected result, status", i_out_data.status, 0);
                end else begin
                    want = match_results_q.pop_front();
                    compare_result(i_out_data, want);
                end
            end
            if (i_in_valid && !i_in_stall)
                match_results_q.push_back(predict_match(i_in_data));
            o_pending <= match_results_q.size();
        end
    end

endmodule

`default_nettype wire

[bench/tb.sv]
// Top of the matcher bench: clock, reset, request and register traffic, verdict.
`default_nettype none

module tb;
    import ncm_pkg::*;

    localparam int   ITEMS          = 1350;
    localparam int   N_PHASES       = 12;
    localparam int   FULL_PHASE     = 5;
    localparam int   HOLD_PHASE     = 6;
    localparam int   HOLD_CYCLES    = 600;
    localparam int   WATCHDOG_LIMIT = 4000;
    localparam int   DRAIN_CYCLES   = 60;
    localparam t_mode MODE_UNUSED   = t_mode'(2'd3);

    logic             clk        = 1'b0;
    logic             rst_n      = 1'b0;
    logic             in_valid   = 1'b0;
    logic             in_stall;
    t_in              in_data    = '0;
    logic             out_valid;
    logic             out_stall  = 1'b0;
    t_out             out_data;
    logic             cfg_valid  = 1'b0;
    logic             cfg_ready;
    t_cfg_idx         cfg_index  = CFG_MATCH_RADIUS;
    logic [REG_W-1:0] cfg_data   = '0;
    int               fail_count;
    int               pending;

    // Stimulus-side view of the registers and the corners of the current frame
    int cur_radius = 128;
    int cur_age    = 10;
    int cur_id     = 0;
    int lu [MAX_CORNERS];
    int lv [MAX_CORNERS];
    int items_sent = 0;

    // Idling controls shared with the stall process
    logic no_idle   = 1'b0;
    logic hold_req  = 1'b0;
    logic hold_done = 1'b0;
    int   hold_cnt  = 0;
    int   stall_left = 0;
    int   idle_cycles = 0;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    nearest_corner_matcher_with_margin_top i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    ncm_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Stall the result side: one long hold-off on request, else random bursts
    always @(posedge clk) begin
        if (hold_req && !hold_done) begin
            out_stall <= 1'b1;
            if (hold_cnt == HOLD_CYCLES) hold_done <= 1'b1;
            hold_cnt <= hold_cnt + 1;
        end else if (no_idle) begin
            out_stall <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else begin : pick_burst
            int r;
            r = $urandom_range(0, 99);
            if (r < 55) begin
                out_stall  <= 1'b0;
                stall_left <= $urandom_range(0, 15);
            end else if (r < 93) begin
                out_stall  <= 1'b1;
                stall_left <= $urandom_range(0, 3);
            end else begin
                out_stall  <= 1'b1;
                stall_left <= $urandom_range(10, 80);
            end
        end
    end

    // Abort when nothing moves on any channel for too long
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int jitter(int m);
        return int'($urandom_range(0, 2 * m)) - m;
    endfunction

    function automatic logic [COORD_W-1:0] clip_coord(int x);
        if (x < 0) return '0;
        if (x > 65535) return 16'hFFFF;
        return x[COORD_W-1:0];
    endfunction

    // Mostly in-age frame numbers, with the edges just outside and noise
    function automatic logic [FRAME_W-1:0] pick_frame();
        int r;
        int span;
        r    = $urandom_range(0, 99);
        span = (cur_age < 65535 - cur_id) ? cur_age : 65535 - cur_id;
        if (r < 80) return FRAME_W'(cur_id + $urandom_range(0, span));
        if (r < 88 && cur_id + cur_age < 65535) return FRAME_W'(cur_id + cur_age + 1);
        if (r < 94 && cur_id > 0) return FRAME_W'(cur_id - 1);
        return FRAME_W'($urandom);
    endfunction

    function automatic t_in make_req(t_mode mode, logic [COORD_W-1:0] u,
                                     logic [COORD_W-1:0] v, logic [GRID_W-1:0] row,
                                     logic [GRID_W-1:0] col, logic [VOTE_W-1:0] votes,
                                     logic [FRAME_W-1:0] frame);
        t_in req;
        req.mode         = mode;
        req.point_u      = u;
        req.point_v      = v;
        req.grid_row     = row;
        req.grid_col     = col;
        req.vote_count   = votes;
        req.frame_number = frame;
        return req;
    endfunction

    function automatic t_in random_req();
        return make_req(t_mode'($urandom_range(0, 3)), COORD_W'($urandom),
                        COORD_W'($urandom), GRID_W'($urandom), GRID_W'($urandom),
                        VOTE_W'($urandom), FRAME_W'($urandom));
    endfunction

    // Offer one request after a random gap and hold it until taken
    task automatic send_req(t_in req);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge clk); while (in_stall);
        items_sent++;
    endtask

    // Drop valid and wait until every owed result has come back
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [REG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic write_regs(int radius, int margin, int age, int id);
        wait_idle();
        write_reg(CFG_MATCH_RADIUS, REG_W'(radius));
        write_reg(CFG_MIN_MARGIN, REG_W'(margin));
        write_reg(CFG_MAX_AGE, REG_W'(age));
        write_reg(CFG_IDENTITY_FRAME, REG_W'(id));
        cfg_valid  <= 1'b0;
        cur_radius = radius;
        cur_age    = age;
        cur_id     = id;
    endtask

    // Query near a loaded corner, sometimes exactly on it
    task automatic send_query_near(int n);
        int pick;
        int du;
        int dv;
        pick = (n > 0) ? $urandom_range(0, n - 1) : 0;
        du   = 0;
        dv   = 0;
        if ($urandom_range(0, 2) != 0) begin
            du = jitter(cur_radius / 2 + 2);
            dv = jitter(cur_radius / 2 + 2);
        end
        send_req(make_req(MODE_QUERY, clip_coord(lu[pick] + du), clip_coord(lv[pick] + dv),
                          GRID_W'($urandom), GRID_W'($urandom), VOTE_W'($urandom),
                          pick_frame()));
    endtask

    // One frame: start, a cluster of corners, then queries; sometimes plain noise
    task automatic run_frame();
        int r;
        int n;
        int k;
        int cu;
        int cv;
        int spread;
        r = $urandom_range(0, 99);
        if (r < 12) begin
            repeat ($urandom_range(1, 6)) send_req(random_req());
        end else begin
            send_req(make_req(MODE_START, COORD_W'($urandom), COORD_W'($urandom),
                              GRID_W'($urandom), GRID_W'($urandom), VOTE_W'($urandom),
                              FRAME_W'($urandom)));
            r = $urandom_range(0, 99);
            n = (r < 5) ? 0 : (r < 80) ? $urandom_range(1, 8) : $urandom_range(9, 24);
            cu = ($urandom_range(0, 3) == 0) ? 65535 * $urandom_range(0, 1) : $urandom_range(0, 65535);
            cv = ($urandom_range(0, 3) == 0) ? 65535 * $urandom_range(0, 1) : $urandom_range(0, 65535);
            spread = 2 * cur_radius + 8;
            if (spread > 4000) spread = 4000;
            for (k = 0; k < n; k++) begin
                lu[k] = clip_coord(cu + jitter(spread));
                lv[k] = clip_coord(cv + jitter(spread));
                send_req(make_req(MODE_LOAD, COORD_W'(lu[k]), COORD_W'(lv[k]),
                                  GRID_W'($urandom), GRID_W'($urandom), VOTE_W'($urandom),
                                  FRAME_W'($urandom)));
            end
            repeat (n + $urandom_range(0, 3)) begin
                if ($urandom_range(0, 19) == 0) send_req(random_req());
                else send_query_near(n);
            end
        end
        if ($urandom_range(0, 29) == 0) wait_idle();
    endtask

    // Fill the table past its capacity, then query it whole
    task automatic fill_table();
        int k;
        send_req(make_req(MODE_START, '0, '0, '0, '0, '0, '0));
        for (k = 0; k < MAX_CORNERS + 3; k++) begin
            if (k < MAX_CORNERS) begin
                lu[k] = $urandom_range(0, 65535);
                lv[k] = $urandom_range(0, 65535);
            end
            send_req(make_req(MODE_LOAD, COORD_W'(lu[k % MAX_CORNERS]),
                              COORD_W'(lv[k % MAX_CORNERS]), GRID_W'($urandom),
                              GRID_W'($urandom), VOTE_W'($urandom), FRAME_W'($urandom)));
        end
        repeat (4) send_query_near(MAX_CORNERS);
    endtask

    initial begin : stimulus
        int phase;
        int target;

        // Hold reset, then start from a clean table
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty table, age limits, extremes, claim, far, exact radius, clamp
        send_req(make_req(MODE_QUERY, '0, '0, '0, '0, 8'hFF, 16'd0));
        send_req(make_req(MODE_QUERY, '0, '0, '0, '0, 8'hFF, 16'd11));
        send_req(make_req(MODE_START, '0, '0, '0, '0, '0, '0));
        send_req(make_req(MODE_LOAD, '0, '0, '0, '0, '0, '0));
        send_req(make_req(MODE_LOAD, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF));
        send_req(make_req(MODE_LOAD, 16'h0100, 16'h0100, 8'h55, 8'hAA, '0, '0));
        send_req(make_req(MODE_QUERY, '0, '0, '0, '0, 8'hFF, 16'd10));
        send_req(make_req(MODE_QUERY, 16'd1, 16'd1, '0, '0, 8'd3, 16'd10));
        send_req(make_req(MODE_QUERY, 16'hFFFF, 16'hFFFF, '0, '0, 8'd7, 16'd10));
        send_req(make_req(MODE_QUERY, 16'h8000, 16'h8000, '0, '0, 8'd9, 16'd5));
        send_req(make_req(MODE_QUERY, 16'h0180, 16'h0100, '0, '0, '0, 16'd0));
        send_req(make_req(MODE_UNUSED, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF));
        send_req(make_req(MODE_QUERY, '0, '0, '0, '0, 8'hFF, 16'hFFFF));

        // Directed: negative age, lone corner, tie, margin pass, claimed best
        write_regs(65535, 16, 65535, 100);
        send_req(make_req(MODE_START, '0, '0, '0, '0, '0, '0));
        send_req(make_req(MODE_LOAD, 16'd1000, 16'd1000, 8'd1, 8'd2, '0, '0));
        send_req(make_req(MODE_QUERY, 16'd1000, 16'd1000, '0, '0, 8'd50, 16'd99));
        send_req(make_req(MODE_QUERY, 16'd1000, 16'd1000, '0, '0, 8'd50, 16'd100));
        send_req(make_req(MODE_LOAD, 16'd1020, 16'd1000, 8'd3, 8'd4, '0, '0));
        send_req(make_req(MODE_QUERY, 16'd1010, 16'd1000, '0, '0, 8'd50, 16'd100));
        send_req(make_req(MODE_QUERY, 16'd1040, 16'd1000, '0, '0, 8'd200, 16'hFFFF));
        send_req(make_req(MODE_QUERY, 16'd1020, 16'd1000, '0, '0, 8'hFF, 16'd100));

        // Random phases, each under its own register setting
        for (phase = 0; phase < N_PHASES; phase++) begin
            case (phase)
                0: write_regs(65535, 0, 65535, 0);
                1: write_regs(0, 0, 0, 65535);
                2: write_regs(200, 65535, 10, 1000);
                3: write_regs(64, 1, 5, 5);
                default: write_regs($urandom_range(8, 600),
                                    ($urandom_range(0, 99) < 40) ? 0 : $urandom_range(1, 48),
                                    $urandom_range(0, 40), $urandom_range(0, 65535));
            endcase
            no_idle <= (phase % 4 == 3);
            if (phase == FULL_PHASE) fill_table();
            if (phase == HOLD_PHASE) hold_req <= 1'b1;
            target = ITEMS * (phase + 1) / N_PHASES;
            while (items_sent < target) run_frame();
        end

        // Drain, then let stray results show up
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire
